/* rtl/etz_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etz_pkg
// Types, codes and calendar tables shared by the epoch time-zone converter.
// ----------------------------------------------------------------------------
package etz_pkg;

    typedef struct packed {
        logic        cmd;
        logic [31:0] time_in;
    } t_in_item;

    typedef struct packed {
        logic [31:0] time_out;
        logic        dst_active;
        logic [11:0] local_year;
        logic [3:0]  local_month;
        logic [4:0]  local_day;
        logic [4:0]  local_hour;
        logic [5:0]  local_minute;
        logic [5:0]  local_second;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOCAL,
        S_DIV,
        S_YEAR,
        S_MONTH,
        S_RMON,
        S_RWEEK,
        S_RMUL,
        S_CMP,
        S_OUT
    } t_state;

    // divider jobs
    typedef enum logic [1:0] {
        J_SEC,
        J_MIN,
        J_HOUR,
        J_WDAY
    } t_job;

    localparam logic [1:0] IDX_ZONE   = 2'd0;
    localparam logic [1:0] IDX_RULE   = 2'd1;
    localparam logic [1:0] RULE_NONE  = 2'd0;
    localparam logic       CMD_TO_UTC = 1'b1;

    localparam logic [11:0] EPOCH_YEAR = 12'd1970;
    localparam logic [11:0] YEAR_2100  = 12'd2100;

    localparam logic [4:0] MONTH_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    // rule table: index (select-1)*2 + {0 start, 1 end}; week 0 means last
    localparam logic [1:0] RULE_WEEK  [6] = '{2'd0, 2'd0, 2'd2, 2'd1, 2'd1, 2'd1};
    localparam logic [3:0] RULE_MONTH [6] = '{4'd3, 4'd10, 4'd3, 4'd11, 4'd10, 4'd4};
    localparam logic [1:0] RULE_HOUR  [6] = '{2'd2, 2'd3, 2'd2, 2'd2, 2'd2, 2'd3};

    // valid for years 1970 to 2106
    function automatic logic is_leap(input logic [11:0] year);
        is_leap = (year[1:0] == 2'b00) && (year != YEAR_2100);
    endfunction

    function automatic logic [4:0] month_len(input logic [11:0] year, input logic [3:0] m0);
        if (m0 == 4'd1) begin
            month_len = is_leap(year) ? 5'd29 : 5'd28;
        end else if (m0 < 4'd12) begin
            month_len = MONTH_LEN[m0];
        end else begin
            month_len = 5'd31;
        end
    endfunction

endpackage

/* rtl/epoch_time_zone_dst_converter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epoch_time_zone_dst_converter
// Converts seconds since 1970 between UTC and local time with a zone offset
// and a daylight saving rule pair, and gives the local calendar breakdown.
// ----------------------------------------------------------------------------
// Usage:
//   configuration channel (i_cfg_*): index 0 writes the signed HHMM zone
//   offset, index 1 the rule select (0 none, 1 Europe, 2 USA, 3 Australia);
//   other indexes are ignored. Write only while the block is idle.
//   input channel (i_in_*): one item, cmd and time_in, is taken when
//   o_in_ready is high; ready stays low until its result has been taken.
//   output channel (o_out_*): one result per item, held until accepted.
// Sequence:
//   reciprocal-multiply division for seconds, minutes and hours, a year walk
//   of one step per year since 1970 (up to 137), up to 12 month steps, and
//   with a rule selected two rule instants, each of up to 11 month steps, a
//   weekday division, a week adjustment and an instant multiply, then the
//   compare and the output. One item is in flight at a time; the shared
//   multiplier and the one-step year and month walks set how long it takes.
// Reset: offset 0, no rule, idle, nothing pending; datapath registers are not reset.
// Stall: a result not yet taken holds the block in S_OUT with o_out_valid high.
// ----------------------------------------------------------------------------
module epoch_time_zone_dst_converter (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [11:0]         i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  etz_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output etz_pkg::t_out_item  o_out_data
);
    import etz_pkg::*;

    t_state      r_state, n_state;
    logic [11:0] r_zone;
    logic [1:0]  r_rule;

    logic        r_cmd;
    logic [31:0] r_tin, r_off, r_local;
    t_job        r_job;
    logic [31:0] r_dq, r_q;
    logic [2:0]  r_rem;
    logic        r_ph;
    logic [5:0]  r_sec, r_min;
    logic [4:0]  r_hour;
    logic [15:0] r_days, r_acc;
    logic [11:0] r_year;
    logic [8:0]  r_t;
    logic [3:0]  r_m0, r_rm;
    logic        r_k;
    logic [16:0] r_dacc;
    logic [31:0] r_start, r_end;
    t_out_item   r_out;

    // zone offset in seconds from the HHMM register
    logic        tz_neg;
    logic [11:0] tz_mag;
    logic [23:0] tz_prod;
    logic [4:0]  tz_q;
    logic [6:0]  tz_r;
    logic [16:0] tz_secs;
    logic [31:0] off_secs;

    always_comb begin
        tz_neg   = r_zone[11];
        tz_mag   = tz_neg ? (12'd0 - r_zone) : r_zone;
        tz_prod  = {12'd0, tz_mag} * 24'd5243;
        tz_q     = tz_prod[23:19];
        tz_r     = 7'(tz_mag - 12'(tz_q) * 12'd100);
        tz_secs  = 17'((17'(tz_q) * 17'd60 + 17'(tz_r)) * 17'd60);
        off_secs = tz_neg ? (32'd0 - 32'(tz_secs)) : 32'(tz_secs);
    end

    // shared divider: reciprocal multiply, quotient from the high bits
    logic [31:0] mu_a, mu_m, mu_q;
    logic [63:0] mu_p;
    logic [5:0]  dv_d, dv_rem;
    always_comb begin
        case (r_job)
            J_SEC, J_MIN: begin
                mu_a = r_dq;
                mu_m = 32'h8888_8889;
                dv_d = 6'd60;
            end
            // divide by 8 first, then by 3
            J_HOUR: begin
                mu_a = {3'd0, r_dq[31:3]};
                mu_m = 32'hAAAA_AAAB;
                dv_d = 6'd24;
            end
            default: begin
                mu_a = r_dq;
                mu_m = 32'd149797;
                dv_d = 6'd7;
            end
        endcase
        mu_p = 64'(mu_a) * 64'(mu_m);
        case (r_job)
            J_SEC, J_MIN: mu_q = 32'(mu_p[63:37]);
            J_HOUR:       mu_q = 32'(mu_p[63:33]);
            default:      mu_q = 32'(mu_p[51:20]);
        endcase
        dv_rem = 6'(r_dq - r_q * 32'(dv_d));
    end

    // rule lookup
    logic [2:0]  ri;
    logic [1:0]  rw;
    logic        r_last;
    logic [3:0]  tmon;
    logic [8:0]  ylen;
    logic [4:0]  mlen_y, mlen_r;
    logic [2:0]  wd;
    logic [4:0]  wadd;
    logic [16:0] dnew;
    logic [31:0] inst;
    logic        dst;
    always_comb begin
        ri     = 3'({r_rule - 2'd1, r_k});
        rw     = RULE_WEEK[ri];
        r_last = (rw == 2'd0);
        tmon   = RULE_MONTH[ri] + (r_last ? 4'd1 : 4'd0);
        ylen   = is_leap(r_year) ? 9'd366 : 9'd365;
        mlen_y = month_len(r_year, r_m0);
        mlen_r = month_len(r_year, r_rm);
        wd     = r_rem;
        wadd   = (wd == 3'd0) ? 5'd0 : 5'(4'd7 - 4'(wd));
        dnew   = r_dacc + 17'(wadd) + (r_last ? 17'd0 : 17'(5'd7 * 5'(rw - 2'd1)))
                 - (r_last ? 17'd7 : 17'd0);
        inst   = 32'(r_dacc * 32'd86400) + 32'(RULE_HOUR[ri]) * 32'd3600;
        dst    = ((r_start < r_end) && (r_local >= r_start) && (r_local < r_end))
              || ((r_start > r_end) && ((r_local >= r_start) || (r_local < r_end)));
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_LOCAL;
            S_LOCAL: n_state = S_DIV;
            S_DIV: begin
                if (r_ph) begin
                    n_state = (r_job == J_HOUR) ? S_YEAR :
                              (r_job == J_WDAY) ? S_RWEEK : S_DIV;
                end
            end
            S_YEAR:  if (32'(r_acc) + 32'(ylen) > 32'(r_days)) n_state = S_MONTH;
            S_MONTH: begin
                if ((r_m0 == 4'd11) || (r_t < 9'(mlen_y))) begin
                    n_state = (r_rule == RULE_NONE) ? S_CMP : S_RMON;
                end
            end
            S_RMON:  if (r_rm >= tmon - 4'd1) n_state = S_DIV;
            S_RWEEK: n_state = S_RMUL;
            S_RMUL:  n_state = r_k ? S_CMP : S_RMON;
            S_CMP:   n_state = S_OUT;
            S_OUT:   if (i_out_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_zone  <= 12'd0;
            r_rule  <= RULE_NONE;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                if (i_cfg_index == IDX_ZONE) r_zone <= i_cfg_data;
                else if (i_cfg_index == IDX_RULE) r_rule <= i_cfg_data[1:0];
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_cmd <= i_in_data.cmd;
                r_tin <= i_in_data.time_in;
                r_off <= off_secs;
            end
            S_LOCAL: begin
                r_local <= (r_cmd == CMD_TO_UTC) ? r_tin : r_tin + r_off;
                r_dq    <= (r_cmd == CMD_TO_UTC) ? r_tin : r_tin + r_off;
                r_ph    <= 1'b0;
                r_job   <= J_SEC;
            end
            S_DIV: begin
                if (!r_ph) begin
                    r_q  <= mu_q;
                    r_ph <= 1'b1;
                end else begin
                    r_ph <= 1'b0;
                    r_dq <= r_q;
                    case (r_job)
                        J_SEC: begin
                            r_sec <= dv_rem;
                            r_job <= J_MIN;
                        end
                        J_MIN: begin
                            r_min <= dv_rem;
                            r_job <= J_HOUR;
                        end
                        J_HOUR: begin
                            r_hour <= 5'(dv_rem);
                            r_days <= r_q[15:0];
                            r_year <= EPOCH_YEAR;
                            r_acc  <= 16'd0;
                        end
                        default: begin
                            r_rem <= 3'(dv_rem);
                        end
                    endcase
                end
            end
            S_YEAR: begin
                if (32'(r_acc) + 32'(ylen) > 32'(r_days)) begin
                    r_t  <= 9'(r_days - r_acc);
                    r_m0 <= 4'd0;
                end else begin
                    r_acc  <= r_acc + 16'(ylen);
                    r_year <= r_year + 12'd1;
                end
            end
            S_MONTH: begin
                if ((r_m0 == 4'd11) || (r_t < 9'(mlen_y))) begin
                    r_k    <= 1'b0;
                    r_rm   <= 4'd0;
                    r_dacc <= 17'(r_acc);
                end else begin
                    r_t  <= r_t - 9'(mlen_y);
                    r_m0 <= r_m0 + 4'd1;
                end
            end
            S_RMON: begin
                if (r_rm >= tmon - 4'd1) begin
                    r_dq  <= 32'(r_dacc) + 32'd4;
                    r_ph  <= 1'b0;
                    r_job <= J_WDAY;
                end else begin
                    r_dacc <= r_dacc + 17'(mlen_r);
                    r_rm   <= r_rm + 4'd1;
                end
            end
            S_RWEEK: r_dacc <= dnew;
            S_RMUL: begin
                if (r_k) r_end <= inst;
                else     r_start <= inst;
                r_k    <= 1'b1;
                r_rm   <= 4'd0;
                r_dacc <= 17'(r_acc);
            end
            S_CMP: begin
                r_out.dst_active   <= (r_rule != RULE_NONE) && dst;
                r_out.time_out     <= (r_cmd == CMD_TO_UTC)
                    ? (r_tin - r_off - (((r_rule != RULE_NONE) && dst) ? 32'd3600 : 32'd0))
                    : (r_local + (((r_rule != RULE_NONE) && dst) ? 32'd3600 : 32'd0));
                r_out.local_year   <= r_year;
                r_out.local_month  <= r_m0 + 4'd1;
                r_out.local_day    <= 5'(r_t + 9'd1);
                r_out.local_hour   <= r_hour;
                r_out.local_minute <= r_min;
                r_out.local_second <= r_sec;
            end
            default: ;
        endcase
    end

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_out_data  = r_out;

endmodule
